// ===== hw/rtl/dss_pkg.sv =====
// ----------------------------------------------------------------------------
// dss_pkg
// shared widths, command, status and hit codes for the dual stack block
// ----------------------------------------------------------------------------
package dss_pkg;

  localparam int DATA_W    = 32;
  localparam int CMD_W     = 3;
  localparam int SIZE_W    = 9;
  localparam int IDX_W     = 8;
  localparam int STAT_W    = 2;
  localparam int FSTK_W    = 2;
  localparam int DEPTH_DEF = 256;

  localparam logic [SIZE_W-1:0] CAP_RESET = 9'd256;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_PEEK   = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_SEARCH = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [FSTK_W-1:0] {
    FSTK_NONE = 2'd0,
    FSTK_A    = 2'd1,
    FSTK_B    = 2'd2
  } fstk_t;

endpackage

// ===== hw/rtl/dss_in_if.sv =====
// ----------------------------------------------------------------------------
// dss_in_if
// command channel: valid/ready handshake with command, stack select and value
// ----------------------------------------------------------------------------
interface dss_in_if import dss_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic                     which_stack;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output command, output which_stack, output value,
                  input ready);
  modport sink   (input valid, input command, input which_stack, input value,
                  output ready);

endinterface

// ===== hw/rtl/dss_out_if.sv =====
// ----------------------------------------------------------------------------
// dss_out_if
// result channel: valid/ready handshake with status, data, hit and sizes
// ----------------------------------------------------------------------------
interface dss_out_if import dss_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] data;
  logic [FSTK_W-1:0]        found_stack;
  logic [IDX_W-1:0]         found_index;
  logic [SIZE_W-1:0]        size_a;
  logic [SIZE_W-1:0]        size_b;

  modport source (output valid, output status, output data, output found_stack,
                  output found_index, output size_a, output size_b, input ready);
  modport sink   (input valid, input status, input data, input found_stack,
                  input found_index, input size_a, input size_b, output ready);

endinterface

// ===== hw/rtl/dss_cfg_if.sv =====
// ----------------------------------------------------------------------------
// dss_cfg_if
// configuration write channel carrying the capacity word
// ----------------------------------------------------------------------------
interface dss_cfg_if import dss_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// ===== hw/rtl/dss_store.sv =====
// ----------------------------------------------------------------------------
// dss_store
// synchronous store with one write port and one registered read port, one write and one read per cycle
// ----------------------------------------------------------------------------
module dss_store import dss_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/dual_stack_shared_array.sv =====
// push, pop, peek and clear: result made in the execute state, registered once the output is free
// search: one store read per cycle while scanning, held while a hit or miss waits for the output
// the store's single read port sets the rate; a new word is taken only back in the idle state
// a new word is accepted while the previous result still waits in the output register
// reset clears both sizes and sets capacity to 256; store contents are not cleared
// ----------------------------------------------------------------------------
// dual_stack_shared_array
// two stacks growing toward each other in one shared store, with search
// ----------------------------------------------------------------------------
module dual_stack_shared_array import dss_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  dss_in_if.sink    in_ch,
  dss_out_if.source out_ch,
  dss_cfg_if.sink   cfg_ch
);

  localparam int AW      = $clog2(DEPTH);
  localparam int IW      = ((AW > SIZE_W + 1) ? AW : SIZE_W + 1) + 2;
  localparam int CAP_MAX = (DEPTH < 511) ? DEPTH : 511;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EXEC   = 4'b0010,
    ST_SRCH_A = 4'b0100,
    ST_SRCH_B = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic                on_b_r, on_b_nxt;
  logic [DATA_W-1:0]   val_r, val_nxt;
  logic [AW-1:0]       addr_r, addr_nxt;
  logic [SIZE_W-1:0]   left_r, left_nxt;
  logic [SIZE_W-1:0]   count_a_r, count_a_nxt;
  logic [SIZE_W-1:0]   count_b_r, count_b_nxt;
  logic [SIZE_W-1:0]   cap_r, cap_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]   out_status_r;
  logic [DATA_W-1:0]   out_data_r;
  logic [FSTK_W-1:0]   out_fstk_r;
  logic [IDX_W-1:0]    out_fidx_r;
  logic [SIZE_W-1:0]   out_size_a_r;
  logic [SIZE_W-1:0]   out_size_b_r;

  logic                in_acc;
  logic                out_free;
  logic                out_load;
  logic [STAT_W-1:0]   res_status;
  logic [DATA_W-1:0]   res_data;
  logic [FSTK_W-1:0]   res_fstk;
  logic [IDX_W-1:0]    res_fidx;

  logic [SIZE_W-1:0]   eff_cap;
  logic [SIZE_W:0]     bt_n;
  logic [IW-1:0]       bt_t;
  logic [AW-1:0]       b_top;
  logic [AW-1:0]       acc_addr;
  logic                is_full;

  logic                mem_we;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  logic [DATA_W-1:0]   mem_rdata;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.data        = out_data_r;
  assign out_ch.found_stack = out_fstk_r;
  assign out_ch.found_index = out_fidx_r;
  assign out_ch.size_a      = out_size_a_r;
  assign out_ch.size_b      = out_size_b_r;

  // capacity limited to the store depth
  assign eff_cap = (cap_r > SIZE_W'(CAP_MAX)) ? SIZE_W'(CAP_MAX) : cap_r;
  assign is_full = ({1'b0, count_a_r} + {1'b0, count_b_r}) >= {1'b0, eff_cap};

  // store index of b's top entry, one deeper for a push
  always_comb begin
    bt_n = {1'b0, count_b_r};
    if (state_r == ST_IDLE && in_ch.command == CMD_PUSH) begin
      bt_n = {1'b0, count_b_r} + 10'd1;
    end
    if ({1'b0, eff_cap} >= bt_n) begin
      bt_t = IW'(eff_cap) - IW'(bt_n);
    end else begin
      bt_t = IW'(eff_cap) + IW'(DEPTH) - IW'(bt_n);
    end
    if (bt_t >= IW'(DEPTH)) begin
      b_top = AW'(bt_t - IW'(DEPTH));
    end else begin
      b_top = AW'(bt_t);
    end
  end

  always_comb begin
    case (in_ch.command)
      CMD_PUSH: begin
        acc_addr = in_ch.which_stack ? b_top : AW'(count_a_r);
      end
      CMD_POP, CMD_PEEK: begin
        acc_addr = in_ch.which_stack ? b_top : AW'(count_a_r - 9'd1);
      end
      CMD_SEARCH: begin
        acc_addr = (count_a_r != '0) ? AW'(count_a_r - 9'd1) : b_top;
      end
      default: begin
        acc_addr = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    on_b_nxt    = on_b_r;
    val_nxt     = val_r;
    addr_nxt    = addr_r;
    left_nxt    = left_r;
    count_a_nxt = count_a_r;
    count_b_nxt = count_b_r;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = addr_r;
    out_load    = 1'b0;
    res_status  = STAT_OK;
    res_data    = '0;
    res_fstk    = FSTK_NONE;
    res_fidx    = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_nxt   = in_ch.command;
          on_b_nxt  = in_ch.which_stack;
          val_nxt   = in_ch.value;
          mem_re    = 1'b1;
          mem_raddr = acc_addr;
          addr_nxt  = acc_addr;
          state_nxt = ST_EXEC;
          if (in_ch.command == CMD_SEARCH) begin
            if (count_a_r != '0) begin
              state_nxt = ST_SRCH_A;
              left_nxt  = count_a_r;
            end else if (count_b_r != '0) begin
              state_nxt = ST_SRCH_B;
              left_nxt  = count_b_r;
            end
          end
        end
      end

      ST_EXEC: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
          case (cmd_r)
            CMD_PUSH: begin
              if (is_full) begin
                res_status = STAT_FULL;
              end else begin
                mem_we = 1'b1;
                if (on_b_r) begin
                  count_b_nxt = count_b_r + 9'd1;
                end else begin
                  count_a_nxt = count_a_r + 9'd1;
                end
              end
            end
            CMD_POP, CMD_PEEK: begin
              if ((on_b_r ? count_b_r : count_a_r) == '0) begin
                res_status = STAT_EMPTY;
              end else begin
                res_data = mem_rdata;
                if (cmd_r == CMD_POP) begin
                  if (on_b_r) begin
                    count_b_nxt = count_b_r - 9'd1;
                  end else begin
                    count_a_nxt = count_a_r - 9'd1;
                  end
                end
              end
            end
            CMD_CLEAR: begin
              count_a_nxt = '0;
              count_b_nxt = '0;
            end
            CMD_SEARCH: begin
              res_status = STAT_NOTFOUND;
            end
            default: begin
              res_status = STAT_OK;
            end
          endcase
        end
      end

      ST_SRCH_A: begin
        if (mem_rdata == val_r) begin
          if (out_free) begin
            out_load  = 1'b1;
            res_fstk  = FSTK_A;
            res_fidx  = IDX_W'(addr_r);
            state_nxt = ST_IDLE;
          end
        end else if (left_r == 9'd1) begin
          if (count_b_r != '0) begin
            mem_re    = 1'b1;
            mem_raddr = b_top;
            addr_nxt  = b_top;
            left_nxt  = count_b_r;
            state_nxt = ST_SRCH_B;
          end else if (out_free) begin
            out_load   = 1'b1;
            res_status = STAT_NOTFOUND;
            state_nxt  = ST_IDLE;
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = addr_r - AW'(1);
          addr_nxt  = addr_r - AW'(1);
          left_nxt  = left_r - 9'd1;
        end
      end

      ST_SRCH_B: begin
        if (mem_rdata == val_r) begin
          if (out_free) begin
            out_load  = 1'b1;
            res_fstk  = FSTK_B;
            res_fidx  = IDX_W'(addr_r);
            state_nxt = ST_IDLE;
          end
        end else if (left_r == 9'd1) begin
          if (out_free) begin
            out_load   = 1'b1;
            res_status = STAT_NOTFOUND;
            state_nxt  = ST_IDLE;
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = (addr_r == AW'(DEPTH - 1)) ? '0 : addr_r + AW'(1);
          addr_nxt  = mem_raddr;
          left_nxt  = left_r - 9'd1;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign cap_nxt = (cfg_ch.valid && cfg_ch.ready) ? cfg_ch.data : cap_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_a_r   <= '0;
      count_b_r   <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
      left_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      count_a_r   <= count_a_nxt;
      count_b_r   <= count_b_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
      left_r      <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    on_b_r <= on_b_nxt;
    val_r  <= val_nxt;
    addr_r <= addr_nxt;
    if (out_load) begin
      out_status_r <= res_status;
      out_data_r   <= res_data;
      out_fstk_r   <= res_fstk;
      out_fidx_r   <= res_fidx;
      out_size_a_r <= count_a_nxt;
      out_size_b_r <= count_b_nxt;
    end
  end

  dss_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (addr_r),
    .wdata (val_r),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  a_wr_only_exec: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_EXEC))
    else $error("store write outside execute");

  a_no_rd_wr: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("store read and write in one cycle");

  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != ST_IDLE))
    else $error("accepted word did not start");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ch.ready))
    else $error("result overwrote a waiting word");

  a_scan_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SRCH_A || state_r == ST_SRCH_B) |-> (left_r != '0))
    else $error("search running with no entries left");

endmodule

// ===== bench/tb_dual_stack_shared_array.sv =====
// ----------------------------------------------------------------------------
// tb_dual_stack_shared_array
// drives command words with random gaps and output stalls, mirrors both
// stacks and the shared store in a scoreboard, and checks every result word
// over a sequence of capacity settings
// ----------------------------------------------------------------------------
import dss_pkg::*;

typedef struct {
  logic [STAT_W-1:0] status;
  logic [DATA_W-1:0] data;
  logic [FSTK_W-1:0] fstk;
  logic [IDX_W-1:0]  idx;
  logic [SIZE_W-1:0] size_a;
  logic [SIZE_W-1:0] size_b;
} stack_result_t;

class stack_mirror;
  logic [DATA_W-1:0] store [DEPTH_DEF];
  int count_a;
  int count_b;
  int capacity;
  int errors;
  stack_result_t pending_results[$];

  function new();
    count_a  = 0;
    count_b  = 0;
    capacity = int'(CAP_RESET);
    errors   = 0;
  endfunction

  function int used_cap();
    return (capacity > DEPTH_DEF) ? DEPTH_DEF : capacity;
  endfunction

  // store index of the top of stack b
  function int b_top();
    int cap;
    cap = used_cap();
    return ((cap >= count_b) ? cap - count_b : cap + DEPTH_DEF - count_b) % DEPTH_DEF;
  endfunction

  function int pending();
    return pending_results.size();
  endfunction

  function void apply_word(logic [CMD_W-1:0] cmd, logic on_b, logic [DATA_W-1:0] val);
    stack_result_t r;
    int cap;
    int idx;
    int top;
    cap      = used_cap();
    r.status = STAT_OK;
    r.data   = '0;
    r.fstk   = FSTK_NONE;
    r.idx    = '0;
    case (cmd)
      CMD_PUSH: begin
        if (count_a + count_b >= cap) begin
          r.status = STAT_FULL;
        end else if (!on_b) begin
          store[count_a % DEPTH_DEF] = val;
          count_a++;
        end else begin
          count_b++;
          store[b_top()] = val;
        end
      end
      CMD_POP, CMD_PEEK: begin
        if ((on_b ? count_b : count_a) == 0) begin
          r.status = STAT_EMPTY;
        end else if (!on_b) begin
          r.data = store[(count_a - 1) % DEPTH_DEF];
          if (cmd == CMD_POP) count_a--;
        end else begin
          r.data = store[b_top()];
          if (cmd == CMD_POP) count_b--;
        end
      end
      CMD_CLEAR: begin
        count_a = 0;
        count_b = 0;
      end
      CMD_SEARCH: begin
        r.status = STAT_NOTFOUND;
        for (int i = count_a; i > 0; i--) begin
          idx = (i - 1) % DEPTH_DEF;
          if (store[idx] === val) begin
            r.status = STAT_OK;
            r.fstk   = FSTK_A;
            r.idx    = IDX_W'(idx);
            break;
          end
        end
        if (r.status == STAT_NOTFOUND) begin
          top = b_top();
          for (int i = 0; i < count_b; i++) begin
            idx = (top + i) % DEPTH_DEF;
            if (store[idx] === val) begin
              r.status = STAT_OK;
              r.fstk   = FSTK_B;
              r.idx    = IDX_W'(idx);
              break;
            end
          end
        end
      end
      default: ;
    endcase
    r.size_a = SIZE_W'(count_a);
    r.size_b = SIZE_W'(count_b);
    pending_results.push_back(r);
  endfunction

  // a value currently held on either stack, for search hits
  function bit held_value(output logic [DATA_W-1:0] v);
    int held;
    int k;
    v    = '0;
    held = count_a + count_b;
    if (held == 0) return 0;
    k = $urandom_range(0, held - 1);
    if (k < count_a) v = store[k];
    else v = store[(b_top() + k - count_a) % DEPTH_DEF];
    return 1;
  endfunction

  function void check_result(stack_result_t got);
    stack_result_t want;
    if (pending_results.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result word: status %0d data %h", got.status, got.data);
      return;
    end
    want = pending_results.pop_front();
    if (got.status !== want.status || got.data !== want.data || got.fstk !== want.fstk ||
        got.idx !== want.idx || got.size_a !== want.size_a || got.size_b !== want.size_b)
    begin
      errors++;
      if (errors <= 10) begin
        $display("mismatch exp: status %0d data %h stack %0d index %0d sizes %0d/%0d",
                 want.status, want.data, want.fstk, want.idx, want.size_a, want.size_b);
        $display("         got: status %0d data %h stack %0d index %0d sizes %0d/%0d",
                 got.status, got.data, got.fstk, got.idx, got.size_a, got.size_b);
      end
    end
  endfunction
endclass

module tb_dual_stack_shared_array;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD  = 10;
  localparam int CYCLE_LIMIT = 2_000_000;

  logic clk = 1'b0;
  logic rst_n;
  int   cycle_count = 0;
  int   in_gap_max = 0;
  int   out_stall_max = 0;

  stack_mirror mirror = new();

  dss_in_if  in_ch ();
  dss_out_if out_ch ();
  dss_cfg_if cfg_ch ();

  dual_stack_shared_array u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_dual_stack_shared_array failed");
      $finish;
    end
  end

  function automatic int draw_gap_max();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 3;
      default: return 10;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return DATA_W'($urandom_range(0, 5));
    if (r == 4) begin
      case ($urandom_range(0, 3))
        0:       return 32'h7fff_ffff;
        1:       return 32'h8000_0000;
        2:       return 32'hffff_ffff;
        default: return 32'h0;
      endcase
    end
    return $urandom();
  endfunction

  task automatic send_word(logic [CMD_W-1:0] cmd, logic on_b, logic [DATA_W-1:0] val);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.command     = cmd;
    in_ch.which_stack = on_b;
    in_ch.value       = val;
    do @(posedge clk); while (!in_ch.ready);
    mirror.apply_word(cmd, on_b, val);
  endtask

  task automatic write_capacity(logic [SIZE_W-1:0] cap);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.data  = cap;
    do @(posedge clk); while (!cfg_ch.ready);
    mirror.capacity = int'(cap);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // fill_len words of mostly pushes, then alternating fill and drain stretches
  task automatic run_random(int n, int fill_len);
    int r;
    bit drain;
    logic [CMD_W-1:0]  cmd;
    logic              on_b;
    logic [DATA_W-1:0] val;
    for (int k = 0; k < n; k++) begin
      r     = $urandom_range(0, 99);
      drain = (k >= fill_len) && (((k / 20) % 2) == 1);
      if (k < fill_len) cmd = (r < 95) ? CMD_PUSH : CMD_SEARCH;
      else if (!drain) cmd = (r < 60) ? CMD_PUSH : (r < 75) ? CMD_POP : (r < 83) ? CMD_PEEK :
                             (r < 97) ? CMD_SEARCH : (r < 99) ? CMD_CLEAR : CMD_PUSH;
      else cmd = (r < 20) ? CMD_PUSH : (r < 65) ? CMD_POP : (r < 80) ? CMD_PEEK :
                 (r < 97) ? CMD_SEARCH : (r < 99) ? CMD_CLEAR : CMD_PUSH;
      if (r == 99 && k >= fill_len)
        cmd = CMD_W'($urandom_range(int'(CMD_SEARCH) + 1, (1 << CMD_W) - 1));
      on_b = 1'($urandom_range(0, 1));
      if (cmd == CMD_SEARCH && $urandom_range(0, 1) == 1) begin
        if (!mirror.held_value(val)) val = pick_value();
      end else begin
        val = pick_value();
      end
      send_word(cmd, on_b, val);
    end
  endtask

  initial begin
    int stall;
    stack_result_t got;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = $urandom_range(0, out_stall_max);
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.status = out_ch.status;
      got.data   = out_ch.data;
      got.fstk   = out_ch.found_stack;
      got.idx    = out_ch.found_index;
      got.size_a = out_ch.size_a;
      got.size_b = out_ch.size_b;
      mirror.check_result(got);
    end
  end

  initial begin
    int caps[] = '{1, 0, 511, 2, 3, 257, 7, 256, 16, 255, 5, 1, 0, 64, 33};
    int n;
    int fill_len;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.command     = CMD_PUSH;
    in_ch.which_stack = 1'b0;
    in_ch.value       = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.data       = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // directed: empty stacks, extreme values, hits on both stacks, unused codes
    send_word(CMD_POP, 1'b0, '0);
    send_word(CMD_PEEK, 1'b1, '0);
    send_word(CMD_SEARCH, 1'b0, 32'h5);
    send_word(CMD_PUSH, 1'b0, 32'h7fff_ffff);
    send_word(CMD_PUSH, 1'b0, 32'h8000_0000);
    send_word(CMD_PUSH, 1'b1, 32'h0);
    send_word(CMD_PUSH, 1'b1, 32'hffff_ffff);
    send_word(CMD_PUSH, 1'b0, 32'h0);
    send_word(CMD_PEEK, 1'b0, '0);
    send_word(CMD_PEEK, 1'b1, '0);
    send_word(CMD_SEARCH, 1'b1, 32'h0);
    send_word(CMD_SEARCH, 1'b0, 32'h7fff_ffff);
    send_word(CMD_SEARCH, 1'b0, 32'hffff_ffff);
    send_word(CMD_SEARCH, 1'b0, 32'h1234_5678);
    for (int u = int'(CMD_SEARCH) + 1; u < (1 << CMD_W); u++)
      send_word(CMD_W'(u), 1'b1, 32'hffff_ffff);
    send_word(CMD_POP, 1'b1, '0);
    send_word(CMD_SEARCH, 1'b0, 32'hffff_ffff);
    send_word(CMD_POP, 1'b1, '0);
    send_word(CMD_POP, 1'b1, '0);
    send_word(CMD_POP, 1'b0, '0);
    send_word(CMD_CLEAR, 1'b0, '0);
    send_word(CMD_PEEK, 1'b0, '0);

    foreach (caps[p]) begin
      wait_idle();
      in_gap_max    = draw_gap_max();
      out_stall_max = draw_gap_max();
      write_capacity(SIZE_W'(caps[p]));
      // stack b entries would move with the new capacity, so clear whenever b holds any
      if (mirror.count_b != 0 || $urandom_range(0, 1) == 1)
        send_word(CMD_CLEAR, 1'b0, '0);
      if (caps[p] == DEPTH_DEF) begin
        n        = 340;
        fill_len = 290;
      end else if (caps[p] >= 200) begin
        n        = 120;
        fill_len = 60;
      end else begin
        n        = 60;
        fill_len = 0;
      end
      run_random(n, fill_len);
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (mirror.errors == 0 && mirror.pending() == 0) begin
      $display("tb_dual_stack_shared_array passed");
    end else begin
      $display("tb_dual_stack_shared_array failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/dss_pkg.sv
hw/rtl/dss_in_if.sv
hw/rtl/dss_out_if.sv
hw/rtl/dss_cfg_if.sv
hw/rtl/dss_store.sv
hw/rtl/dual_stack_shared_array.sv
bench/tb_dual_stack_shared_array.sv
